// ----- rtl/core/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C EEPROM byte master and its step logic.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	// Bus phase, one-hot
	typedef enum logic [16:0] {
		P_IDLE    = 17'h00001,
		P_STA_A   = 17'h00002,
		P_STA_B   = 17'h00004,
		P_STA_C   = 17'h00008,
		P_TX_LO   = 17'h00010,
		P_TX_HI   = 17'h00020,
		P_ACK_LO  = 17'h00040,
		P_ACK_HI  = 17'h00080,
		P_RS_A    = 17'h00100,
		P_RX_LO   = 17'h00200,
		P_RX_HI   = 17'h00400,
		P_MACK_LO = 17'h00800,
		P_MACK_HI = 17'h01000,
		P_STO_A   = 17'h02000,
		P_STO_B   = 17'h04000,
		P_STO_C   = 17'h08000,
		P_WAIT    = 17'h10000
	} phase_t;

	// Byte currently on the bus
	typedef enum logic [1:0] {
		SEG_DEVW = 2'd0,
		SEG_WORD = 2'd1,
		SEG_DATA = 2'd2,
		SEG_DEVR = 2'd3
	} seg_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_PHASE_TICKS = 2'd0,
		CFG_WRITE_WAIT  = 2'd1,
		CFG_DEV_SELECT  = 2'd2
	} cfg_idx_t;

	localparam int unsigned CFG_DATA_W = 20;

	localparam logic [9:0]  PHASE_TICKS_RST = 10'd2;
	localparam logic [19:0] WRITE_WAIT_RST  = 20'd10000;
	localparam logic [6:0]  DEV_SELECT_RST  = 7'd80;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic [9:0]  phase_ticks;
		logic [19:0] write_wait_ticks;
		logic [6:0]  device_select;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		seg_t        seg;
		logic [3:0]  bit_count;
		logic [7:0]  shift_reg;
		logic [9:0]  tick_count;
		logic [19:0] wait_count;
		logic        latched_op;
		logic [7:0]  latched_addr;
		logic [7:0]  latched_data;
		logic [7:0]  read_byte;
		logic        nack_flag;
	} state_t;

	localparam state_t STATE_RST = '{
		phase:        P_IDLE,
		seg:          SEG_DEVW,
		bit_count:    4'd0,
		shift_reg:    8'd0,
		tick_count:   10'd0,
		wait_count:   20'd0,
		latched_op:   1'b0,
		latched_addr: 8'd0,
		latched_data: 8'd0,
		read_byte:    8'd0,
		nack_flag:    1'b0
	};

	// Line levels and status shown for one tick
	typedef struct packed {
		logic scl;
		logic sda;
		logic busy;
		logic done;
	} res_t;

endpackage

// ----- rtl/core/i2cm_step.sv -----
// ----------------------------------------------------------------------------
// i2cm_step
// Next-state and line-level logic for one time-base tick of the I2C master.
// ----------------------------------------------------------------------------
module i2cm_step (
	input  i2cm_pkg::state_t st,
	input  i2cm_pkg::cfg_t   cfg,
	input  logic             request,
	input  logic             opcode,
	input  logic [7:0]       word_addr,
	input  logic [7:0]       wr_data,
	input  logic             sda_in,
	output i2cm_pkg::state_t st_nxt,
	output i2cm_pkg::res_t   res
);
	import i2cm_pkg::*;

	logic [9:0]  ph;
	logic [10:0] tick_inc;
	logic [20:0] wait_inc;
	logic [3:0]  bit_inc;
	logic [7:0]  rx_shift;
	logic        done;

	// Advance the bus sequence by one tick
	always_comb begin
		st_nxt   = st;
		done     = 1'b0;
		ph       = (cfg.phase_ticks == 10'd0) ? 10'd1 : cfg.phase_ticks;
		tick_inc = {1'b0, st.tick_count} + 11'd1;
		wait_inc = {1'b0, st.wait_count} + 21'd1;
		bit_inc  = st.bit_count + 4'd1;
		rx_shift = {st.shift_reg[6:0], sda_in};

		unique case (st.phase)
			P_IDLE: begin
				if (request) begin
					st_nxt.latched_op   = opcode;
					st_nxt.latched_addr = word_addr;
					st_nxt.latched_data = wr_data;
					st_nxt.nack_flag    = 1'b0;
					st_nxt.seg          = SEG_DEVW;
					st_nxt.shift_reg    = {cfg.device_select, OP_WRITE};
					st_nxt.bit_count    = 4'd0;
					st_nxt.tick_count   = 10'd0;
					st_nxt.phase        = P_STA_A;
				end
			end
			P_WAIT: begin
				if (wait_inc >= {1'b0, cfg.write_wait_ticks}) begin
					st_nxt.phase      = P_IDLE;
					st_nxt.wait_count = 20'd0;
					done              = 1'b1;
				end else begin
					st_nxt.wait_count = wait_inc[19:0];
				end
			end
			default: begin
				if (tick_inc >= {1'b0, ph}) begin
					// End of a timed step: pick the next bus phase
					st_nxt.tick_count = 10'd0;
					unique case (st.phase)
						P_STA_A: st_nxt.phase = P_STA_B;
						P_STA_B: st_nxt.phase = P_STA_C;
						P_STA_C: begin
							st_nxt.phase     = P_TX_LO;
							st_nxt.bit_count = 4'd0;
						end
						P_TX_LO: st_nxt.phase = P_TX_HI;
						P_TX_HI: begin
							st_nxt.shift_reg = {st.shift_reg[6:0], 1'b0};
							st_nxt.bit_count = bit_inc;
							st_nxt.phase     = (bit_inc >= 4'd8) ? P_ACK_LO : P_TX_LO;
						end
						P_ACK_LO: st_nxt.phase = P_ACK_HI;
						P_ACK_HI: begin
							if (sda_in) begin
								// Missed acknowledge: abort with a stop
								st_nxt.nack_flag = 1'b1;
								st_nxt.phase     = P_STO_A;
							end else begin
								unique case (st.seg)
									SEG_DEVW: begin
										st_nxt.seg       = SEG_WORD;
										st_nxt.shift_reg = st.latched_addr;
										st_nxt.bit_count = 4'd0;
										st_nxt.phase     = P_TX_LO;
									end
									SEG_WORD: begin
										if (st.latched_op == OP_WRITE) begin
											st_nxt.seg       = SEG_DATA;
											st_nxt.shift_reg = st.latched_data;
											st_nxt.bit_count = 4'd0;
											st_nxt.phase     = P_TX_LO;
										end else begin
											st_nxt.seg       = SEG_DEVR;
											st_nxt.shift_reg = {cfg.device_select, OP_READ};
											st_nxt.phase     = P_RS_A;
										end
									end
									SEG_DATA: st_nxt.phase = P_STO_A;
									default: begin
										st_nxt.shift_reg = 8'd0;
										st_nxt.bit_count = 4'd0;
										st_nxt.phase     = P_RX_LO;
									end
								endcase
							end
						end
						P_RS_A:  st_nxt.phase = P_STA_A;
						P_RX_LO: st_nxt.phase = P_RX_HI;
						P_RX_HI: begin
							st_nxt.shift_reg = rx_shift;
							st_nxt.bit_count = bit_inc;
							if (bit_inc >= 4'd8) begin
								st_nxt.read_byte = rx_shift;
								st_nxt.phase     = P_MACK_LO;
							end else begin
								st_nxt.phase = P_RX_LO;
							end
						end
						P_MACK_LO: st_nxt.phase = P_MACK_HI;
						P_MACK_HI: st_nxt.phase = P_STO_A;
						P_STO_A:   st_nxt.phase = P_STO_B;
						P_STO_B:   st_nxt.phase = P_STO_C;
						P_STO_C: begin
							// Hold busy for the write cycle after a clean write, unless the write wait is zero
							if (st.latched_op == OP_WRITE && !st.nack_flag &&
							    cfg.write_wait_ticks != 20'd0) begin
								st_nxt.wait_count = 20'd0;
								st_nxt.phase      = P_WAIT;
							end else begin
								st_nxt.phase = P_IDLE;
								done         = 1'b1;
							end
						end
						default: begin
							st_nxt.phase = P_IDLE;
							done         = 1'b1;
						end
					endcase
				end else begin
					st_nxt.tick_count = tick_inc[9:0];
				end
			end
		endcase
	end

	// Decode line levels from the new phase
	always_comb begin
		res.busy = (st_nxt.phase != P_IDLE);
		res.done = done;
		unique case (st_nxt.phase)
			P_STA_B: begin
				res.scl = 1'b1;
				res.sda = 1'b0;
			end
			P_STA_C, P_STO_A: begin
				res.scl = 1'b0;
				res.sda = 1'b0;
			end
			P_TX_LO: begin
				res.scl = 1'b0;
				res.sda = st_nxt.shift_reg[7];
			end
			P_TX_HI: begin
				res.scl = 1'b1;
				res.sda = st_nxt.shift_reg[7];
			end
			P_ACK_LO, P_RS_A, P_RX_LO, P_MACK_LO: begin
				res.scl = 1'b0;
				res.sda = 1'b1;
			end
			P_STO_B: begin
				res.scl = 1'b1;
				res.sda = 1'b0;
			end
			default: begin
				res.scl = 1'b1;
				res.sda = 1'b1;
			end
		endcase
	end

endmodule

// ----- rtl/core/i2c_eeprom_byte_master.sv -----
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master: one input transfer per tick, result valid in the next cycle.
// Throughput one transfer per cycle while out_ready does not stall the result register.
// Reset (arst_n low) goes idle with no result valid and state and config at defaults.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_master (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration writes
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [i2cm_pkg::CFG_DATA_W-1:0]     cfg_data,
	// tick input
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                request,
	input  logic                                opcode,
	input  logic [7:0]                          word_addr,
	input  logic [7:0]                          wr_data,
	input  logic                                sda_in,
	// tick result
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                scl_out,
	output logic                                sda_out,
	output logic                                busy_res,
	output logic                                done_res,
	output logic [7:0]                          rd_data,
	output logic                                nack
);
	import i2cm_pkg::*;

	cfg_t   cfg_q;
	state_t st_q;
	state_t st_nxt;
	res_t   res;
	logic   out_valid_q;
	res_t   res_q;
	logic [7:0] rd_data_q;
	logic       nack_q;
	logic       in_xfer;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_ticks      <= PHASE_TICKS_RST;
			cfg_q.write_wait_ticks <= WRITE_WAIT_RST;
			cfg_q.device_select    <= DEV_SELECT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PHASE_TICKS: cfg_q.phase_ticks      <= cfg_data[9:0];
				CFG_WRITE_WAIT:  cfg_q.write_wait_ticks <= cfg_data[19:0];
				CFG_DEV_SELECT:  cfg_q.device_select    <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	i2cm_step u_step (
		.st        (st_q),
		.cfg       (cfg_q),
		.request   (request),
		.opcode    (opcode),
		.word_addr (word_addr),
		.wr_data   (wr_data),
		.sda_in    (sda_in),
		.st_nxt    (st_nxt),
		.res       (res)
	);

	// Take a new tick whenever the result register is free or draining
	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	// Advance state and result valid on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= STATE_RST;
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			st_q        <= st_nxt;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold result payload until the next transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_q     <= res;
			rd_data_q <= st_nxt.read_byte;
			nack_q    <= st_nxt.nack_flag;
		end
	end

	assign out_valid = out_valid_q;
	assign scl_out   = res_q.scl;
	assign sda_out   = res_q.sda;
	assign busy_res  = res_q.busy;
	assign done_res  = res_q.done;
	assign rd_data   = rd_data_q;
	assign nack      = nack_q;

`ifndef NO_ASSERTIONS
	// A finished transfer is never reported as still busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done shown while busy");

	// Idle lines are released
	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> scl_out && sda_out)
		else $error("lines driven while idle");

	// Every accepted tick yields a result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted tick produced no result");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C EEPROM byte master. Each tick is sent as a
// valid/ready transfer and its line levels and status are predicted by a
// tick-level model of the bus sequencer. A small EEPROM responder answers
// acknowledges and read data. A directed table comes first, then random
// accesses under random register settings.
// ----------------------------------------------------------------------------
module testbench;
	import i2cm_pkg::*;

	// Line levels and status of one tick
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rd;
		logic       nack;
	} tick_result_t;

	// One directed row: optional register setting, the first tick, responder
	// behavior, and a typed result for the tick that ends the row
	typedef struct packed {
		bit           cfg;
		logic [9:0]   pt;
		logic [19:0]  ww;
		logic [6:0]   ds;
		logic         req;
		logic         op;
		logic [7:0]   addr;
		logic [7:0]   data;
		logic         sda;
		bit           miss;
		seg_t         miss_at;
		logic [7:0]   sbyte;
		bit           typed;
		tick_result_t want;
	} dir_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [1:0]            cfg_index = CFG_PHASE_TICKS;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic                  request   = 1'b0;
	logic                  opcode    = OP_WRITE;
	logic [7:0]            word_addr = 8'h00;
	logic [7:0]            wr_data   = 8'h00;
	logic                  sda_in    = 1'b1;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  scl_out;
	logic                  sda_out;
	logic                  busy_res;
	logic                  done_res;
	logic [7:0]            rd_data;
	logic                  nack;

	// Bus sequencer model state and register copies
	phase_t      st_phase;
	seg_t        st_seg;
	logic [3:0]  st_bits;
	logic [7:0]  st_shift;
	logic [9:0]  st_tick;
	logic [19:0] st_wait;
	logic        st_op;
	logic [7:0]  st_addr;
	logic [7:0]  st_data;
	logic [7:0]  st_rd;
	logic        st_nack;
	logic [9:0]  cf_phase_ticks;
	logic [19:0] cf_write_wait;
	logic [6:0]  cf_dev;

	// EEPROM responder behavior for the current access
	logic        slave_miss;
	seg_t        slave_miss_at;
	logic [7:0]  slave_byte;
	logic        slave_noise;

	tick_result_t due_ticks[$];
	int           ticks_sent     = 0;
	int           errors         = 0;
	int           hold_left      = 0;
	bit           quiet          = 1'b0;
	bit           long_hold_req  = 1'b0;
	bit           long_hold_done = 1'b0;

	localparam tick_result_t IDLE_CLEAR = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};

	dir_row_t plan [18] = '{
		// idle lines after reset, field extremes, no request
		'{1'b0, 10'd0, 20'd0, 7'd0, 1'b0, OP_WRITE, 8'h00, 8'h00, 1'b0,
			1'b0, SEG_DEVW, 8'h00, 1'b1, IDLE_CLEAR},
		'{1'b0, 10'd0, 20'd0, 7'd0, 1'b0, OP_READ, 8'hFF, 8'hFF, 1'b1,
			1'b0, SEG_DEVW, 8'h00, 1'b1, IDLE_CLEAR},
		'{1'b0, 10'd0, 20'd0, 7'd0, 1'b0, OP_WRITE, 8'h00, 8'hFF, 1'b0,
			1'b0, SEG_DEVW, 8'h00, 1'b1, IDLE_CLEAR},
		// read with the reset register values, then a write aborted on its data byte
		'{1'b0, 10'd0, 20'd0, 7'd0, 1'b1, OP_READ, 8'h00, 8'h00, 1'b1,
			1'b0, SEG_DEVW, 8'hA5, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'hA5, 1'b0}},
		'{1'b0, 10'd0, 20'd0, 7'd0, 1'b1, OP_WRITE, 8'hFF, 8'h00, 1'b0,
			1'b1, SEG_DATA, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'hA5, 1'b1}},
		// fastest clocking, no write recovery, top device address
		'{1'b1, 10'd1, 20'd0, 7'd127, 1'b1, OP_WRITE, 8'h5A, 8'hFF, 1'b1,
			1'b0, SEG_DEVW, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'hA5, 1'b0}},
		'{1'b0, 10'd0, 20'd0, 7'd0, 1'b1, OP_READ, 8'hFF, 8'h00, 1'b0,
			1'b0, SEG_DEVW, 8'hFF, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'hFF, 1'b0}},
		'{1'b0, 10'd0, 20'd0, 7'd0, 1'b1, OP_READ, 8'h80, 8'h00, 1'b0,
			1'b0, SEG_DEVW, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
		// missed acknowledge on each byte of a write and on the word and read device bytes of a read
		'{1'b0, 10'd0, 20'd0, 7'd0, 1'b1, OP_WRITE, 8'h11, 8'h22, 1'b0,
			1'b1, SEG_DEVW, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1}},
		'{1'b0, 10'd0, 20'd0, 7'd0, 1'b1, OP_WRITE, 8'h33, 8'h44, 1'b0,
			1'b1, SEG_WORD, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1}},
		'{1'b0, 10'd0, 20'd0, 7'd0, 1'b1, OP_WRITE, 8'h55, 8'h66, 1'b0,
			1'b1, SEG_DATA, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1}},
		'{1'b0, 10'd0, 20'd0, 7'd0, 1'b1, OP_READ, 8'h77, 8'h00, 1'b0,
			1'b1, SEG_WORD, 8'hEE, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1}},
		'{1'b0, 10'd0, 20'd0, 7'd0, 1'b1, OP_READ, 8'h99, 8'h00, 1'b0,
			1'b1, SEG_DEVR, 8'hEE, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1}},
		// a good access clears nack
		'{1'b0, 10'd0, 20'd0, 7'd0, 1'b1, OP_READ, 8'hC3, 8'h00, 1'b0,
			1'b0, SEG_DEVW, 8'h3C, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h3C, 1'b0}},
		// zero phase ticks, one tick of write recovery, device address zero
		'{1'b1, 10'd0, 20'd1, 7'd0, 1'b1, OP_WRITE, 8'h01, 8'h80, 1'b0,
			1'b0, SEG_DEVW, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h3C, 1'b0}},
		'{1'b0, 10'd0, 20'd0, 7'd0, 1'b1, OP_READ, 8'h7F, 8'h00, 1'b0,
			1'b0, SEG_DEVW, 8'h81, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h81, 1'b0}},
		// longest recovery setting, aborted on the first byte so no recovery
		'{1'b1, 10'd4, 20'hFFFFF, 7'h55, 1'b1, OP_WRITE, 8'hAA, 8'h55, 1'b0,
			1'b1, SEG_DEVW, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h81, 1'b1}},
		'{1'b1, 10'd3, 20'd5, 7'h2A, 1'b1, OP_WRITE, 8'h0F, 8'hF0, 1'b0,
			1'b0, SEG_DEVW, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h81, 1'b0}}
	};

	i2c_eeprom_byte_master i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.request   (request),
		.opcode    (opcode),
		.word_addr (word_addr),
		.wr_data   (wr_data),
		.sda_in    (sda_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.scl_out   (scl_out),
		.sda_out   (sda_out),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.rd_data   (rd_data),
		.nack      (nack)
	);

	always #6 clk = ~clk;

	// Close one timed line level and pick the next; returns 1 when going idle
	function automatic bit close_level(input logic sda);
		phase_t nxt;
		bit     fin;
		nxt = P_IDLE;
		fin = 1'b0;
		case (st_phase)
			P_STA_A: nxt = P_STA_B;
			P_STA_B: nxt = P_STA_C;
			P_STA_C: begin
				nxt = P_TX_LO;
				st_bits = 4'd0;
			end
			P_TX_LO: nxt = P_TX_HI;
			P_TX_HI: begin
				st_shift = st_shift << 1;
				st_bits = st_bits + 4'd1;
				nxt = (st_bits >= 4'd8) ? P_ACK_LO : P_TX_LO;
			end
			P_ACK_LO: nxt = P_ACK_HI;
			P_ACK_HI: begin
				if (sda) begin
					st_nack = 1'b1;
					nxt = P_STO_A;
				end else begin
					case (st_seg)
						SEG_DEVW: begin
							st_seg = SEG_WORD;
							st_shift = st_addr;
							st_bits = 4'd0;
							nxt = P_TX_LO;
						end
						SEG_WORD: begin
							if (st_op == OP_WRITE) begin
								st_seg = SEG_DATA;
								st_shift = st_data;
								st_bits = 4'd0;
								nxt = P_TX_LO;
							end else begin
								st_seg = SEG_DEVR;
								st_shift = {cf_dev, OP_READ};
								nxt = P_RS_A;
							end
						end
						SEG_DATA: nxt = P_STO_A;
						default: begin
							st_shift = 8'h00;
							st_bits = 4'd0;
							nxt = P_RX_LO;
						end
					endcase
				end
			end
			P_RS_A: nxt = P_STA_A;
			P_RX_LO: nxt = P_RX_HI;
			P_RX_HI: begin
				st_shift = {st_shift[6:0], sda};
				st_bits = st_bits + 4'd1;
				if (st_bits >= 4'd8) begin
					st_rd = st_shift;
					nxt = P_MACK_LO;
				end else begin
					nxt = P_RX_LO;
				end
			end
			P_MACK_LO: nxt = P_MACK_HI;
			P_MACK_HI: nxt = P_STO_A;
			P_STO_A: nxt = P_STO_B;
			P_STO_B: nxt = P_STO_C;
			P_STO_C: begin
				if (st_op == OP_WRITE && !st_nack && cf_write_wait != 20'd0) begin
					st_wait = 20'd0;
					nxt = P_WAIT;
				end else begin
					fin = 1'b1;
				end
			end
			default: fin = 1'b1;
		endcase
		st_phase = nxt;
		st_tick = 10'd0;
		return fin;
	endfunction

	// Advance the sequencer model by one tick and form the lines shown after it
	task automatic step_master(input logic req, input logic op, input logic [7:0] addr,
			input logic [7:0] data, input logic sda, output tick_result_t r);
		int ph;
		bit fin;
		ph = (cf_phase_ticks == 10'd0) ? 1 : int'(cf_phase_ticks);
		fin = 1'b0;
		if (st_phase == P_IDLE) begin
			if (req) begin
				st_op = op;
				st_addr = addr;
				st_data = data;
				st_nack = 1'b0;
				st_seg = SEG_DEVW;
				st_shift = {cf_dev, OP_WRITE};
				st_bits = 4'd0;
				st_tick = 10'd0;
				st_phase = P_STA_A;
			end
		end else if (st_phase == P_WAIT) begin
			if (int'(st_wait) + 1 >= int'(cf_write_wait)) begin
				st_phase = P_IDLE;
				st_wait = 20'd0;
				fin = 1'b1;
			end else begin
				st_wait = st_wait + 20'd1;
			end
		end else if (int'(st_tick) + 1 >= ph) begin
			fin = close_level(sda);
		end else begin
			st_tick = st_tick + 10'd1;
		end

		// decode line levels from the new phase
		r.scl = 1'b1;
		r.sda = 1'b1;
		case (st_phase)
			P_STA_B: r.sda = 1'b0;
			P_STA_C, P_STO_A: begin
				r.scl = 1'b0;
				r.sda = 1'b0;
			end
			P_TX_LO: begin
				r.scl = 1'b0;
				r.sda = st_shift[7];
			end
			P_TX_HI: r.sda = st_shift[7];
			P_ACK_LO, P_RS_A, P_RX_LO, P_MACK_LO: r.scl = 1'b0;
			P_STO_B: r.sda = 1'b0;
			default: ;
		endcase
		r.busy = (st_phase != P_IDLE);
		r.done = fin;
		r.rd = st_rd;
		r.nack = st_nack;
	endtask

	// EEPROM side of SDA: acknowledge, data bits, or noise
	function automatic logic slave_sda();
		if (slave_noise)
			return 1'($urandom_range(0, 1));
		case (st_phase)
			P_ACK_LO, P_ACK_HI: return slave_miss && (st_seg == slave_miss_at);
			P_RX_LO, P_RX_HI: return slave_byte[3'd7 - st_bits[2:0]];
			default: return 1'($urandom_range(0, 1));
		endcase
	endfunction

	// Offer one tick, hold it until the transfer, then predict its result
	task automatic send_tick(input logic req, input logic op, input logic [7:0] addr,
			input logic [7:0] data, input logic sda, input bit use_want,
			input tick_result_t want);
		tick_result_t pred;
		int           gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		request   <= req;
		opcode    <= op;
		word_addr <= addr;
		wr_data   <= data;
		sda_in    <= sda;
		do @(posedge clk); while (!in_ready);
		step_master(req, op, addr, data, sda, pred);
		due_ticks.push_back((use_want && st_phase == P_IDLE) ? want : pred);
		ticks_sent++;
	endtask

	// Send the first tick and keep ticking until the sequencer is idle again
	task automatic run_access(input logic req, input logic op, input logic [7:0] addr,
			input logic [7:0] data, input logic sda, input bit use_want,
			input tick_result_t want);
		send_tick(req, op, addr, data, sda, use_want, want);
		while (st_phase != P_IDLE)
			send_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)), 8'($urandom),
				8'($urandom), slave_sda(), use_want, want);
	endtask

	// Drop valid and let every outstanding result come back
	task automatic settle();
		in_valid <= 1'b0;
		while (due_ticks.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write all three registers back to back, junk above the phase-tick and device widths
	task automatic program_regs(input logic [9:0] pt, input logic [19:0] ww,
			input logic [6:0] ds);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PHASE_TICKS;
		cfg_data  <= {10'($urandom), pt};
		@(posedge clk);
		cfg_index <= CFG_WRITE_WAIT;
		cfg_data  <= ww;
		@(posedge clk);
		cfg_index <= CFG_DEV_SELECT;
		cfg_data  <= {13'($urandom), ds};
		@(posedge clk);
		cfg_we    <= 1'b0;
		cf_phase_ticks = pt;
		cf_write_wait = ww;
		cf_dev = ds;
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Result side: check each transfer, then decide ready for the next cycle
	always @(posedge clk) begin
		tick_result_t got;
		tick_result_t want;
		if (out_valid && out_ready) begin
			got = {scl_out, sda_out, busy_res, done_res, rd_data, nack};
			if (due_ticks.size() == 0) begin
				$display("%0t ns: result with none expected, expected none, actual %0h",
					$time, got);
				errors++;
			end else begin
				want = due_ticks.pop_front();
				check_field("scl_out", 8'(want.scl), 8'(got.scl));
				check_field("sda_out", 8'(want.sda), 8'(got.sda));
				check_field("busy_res", 8'(want.busy), 8'(got.busy));
				check_field("done_res", 8'(want.done), 8'(got.done));
				check_field("rd_data", want.rd, got.rd);
				check_field("nack", 8'(want.nack), 8'(got.nack));
			end
		end

		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (long_hold_req && !long_hold_done) begin
			// hold off long enough for the block to back up into its input
			out_ready <= 1'b0;
			hold_left = 299;
			long_hold_done = 1'b1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			out_ready <= 1'b0;
			hold_left = $urandom_range(0, 3);
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		logic [9:0]  pt;
		logic [19:0] ww;
		int          base;

		// model state and registers after reset
		st_phase = P_IDLE;
		st_seg = SEG_DEVW;
		st_bits = 4'd0;
		st_shift = 8'h00;
		st_tick = 10'd0;
		st_wait = 20'd0;
		st_op = OP_WRITE;
		st_addr = 8'h00;
		st_data = 8'h00;
		st_rd = 8'h00;
		st_nack = 1'b0;
		cf_phase_ticks = PHASE_TICKS_RST;
		cf_write_wait = WRITE_WAIT_RST;
		cf_dev = DEV_SELECT_RST;
		slave_noise = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (plan[i]) begin
			if (plan[i].cfg) begin
				settle();
				program_regs(plan[i].pt, plan[i].ww, plan[i].ds);
			end
			slave_miss = plan[i].miss;
			slave_miss_at = plan[i].miss_at;
			slave_byte = plan[i].sbyte;
			run_access(plan[i].req, plan[i].op, plan[i].addr, plan[i].data, plan[i].sda,
				plan[i].typed, plan[i].want);
		end

		// random accesses in groups under random register settings
		base = ticks_sent;
		while (ticks_sent - base < 300) begin
			case ($urandom_range(0, 7))
				0: pt = 10'd0;
				1, 2, 3: pt = 10'd1;
				4, 5: pt = 10'd2;
				default: pt = 10'($urandom_range(3, 5));
			endcase
			case ($urandom_range(0, 5))
				0: ww = 20'd0;
				1: ww = 20'd1;
				default: ww = 20'($urandom_range(2, 16));
			endcase
			settle();
			program_regs(pt, ww, 7'($urandom));
			repeat ($urandom_range(1, 4)) begin
				if (ticks_sent - base >= 50)
					long_hold_req = 1'b1;
				if (ticks_sent - base >= 200)
					quiet = 1'b1;
				repeat ($urandom_range(0, 3))
					send_tick(1'b0, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
						1'($urandom_range(0, 1)), 1'b0, '0);
				slave_miss = ($urandom_range(0, 7) == 0);
				slave_miss_at = seg_t'($urandom_range(0, 3));
				slave_byte = 8'($urandom);
				slave_noise = ($urandom_range(0, 15) == 0);
				run_access(1'b1, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
					1'($urandom_range(0, 1)), 1'b0, '0);
			end
		end

		// drain and finish
		in_valid <= 1'b0;
		while (due_ticks.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0) begin
			$display("** i2c_eeprom_byte_master: PASSED **");
		end else begin
			$display("** i2c_eeprom_byte_master: FAILED **");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("** i2c_eeprom_byte_master: FAILED **");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_step.sv
rtl/core/i2c_eeprom_byte_master.sv
tb/testbench.sv
